// ===== rtl/mesh_route_table_engine_macros.svh =====
// Assertion macros for the mesh route table engine checker.
// Each macro expands to one labeled concurrent assertion clocked on i_clk.
`ifndef MESH_ROUTE_TABLE_ENGINE_MACROS_SVH
`define MESH_ROUTE_TABLE_ENGINE_MACROS_SVH

// Implication in the same cycle, off while reset is asserted.
`define MRTE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, also checked across reset.
`define MRTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mrte_pkg.sv =====
// Package for the mesh route table engine: item, command and result types,
// op codes, FSM states and fixed constants. No dependencies.
`timescale 1ns / 1ps

package mrte_pkg;

    localparam int MAX_RUN     = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        OP_UPDATE  = 2'd0,
        OP_CHECK   = 2'd1,
        OP_REQUEST = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        CFG_IS_GATEWAY = 2'd0,
        CFG_GATEWAY_ID = 2'd1,
        CFG_HOP_LIMIT  = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] dest_id;
        logic [7:0] hop_value;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        logic       forward;
        logic [7:0] forward_hop;
        logic [7:0] entry_dest;
        logic [7:0] entry_hop;
        logic       entry_valid;
        logic [4:0] entry_count;
        logic       dropped;
        logic [7:0] best_dest;
        logic [7:0] best_hop;
        logic       last;
    } t_result;

    // Classified item handed from the front to the back.
    typedef struct packed {
        t_op        op;
        logic [7:0] dest_id;
        logic [7:0] hop_value;
        logic [7:0] link_hop;   // hop_value + 1, saturating
        logic [7:0] dec_hop;    // hop_value - 1, saturating at zero
    } t_cmd;

    typedef struct packed {
        logic       is_gateway;
        logic [7:0] gateway_id;
        logic [7:0] initial_hop_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0] dest;
        logic [7:0] hop;
    } t_entry;

endpackage

// ===== rtl/mrte_front.sv =====
// Front stage: accepts items, decodes the op and precomputes the hop
// arithmetic, then hands the command to the queue. Uses mrte_pkg.
`timescale 1ns / 1ps

module mrte_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  mrte_pkg::t_item      i_item,
    input  logic                 i_q_ready,
    output logic                 o_busy,
    output logic                 o_push,
    output mrte_pkg::t_cmd       o_cmd
);

    logic           r_valid, n_valid;
    mrte_pkg::t_cmd r_cmd, n_cmd;
    logic           accept;

    assign o_busy = r_valid && !i_q_ready;
    assign o_push = r_valid && i_q_ready;
    assign accept = i_start && !o_busy;
    assign o_cmd  = r_cmd;

    always_comb begin
        n_cmd           = r_cmd;
        n_cmd.op        = mrte_pkg::t_op'(i_item.op);
        n_cmd.dest_id   = i_item.dest_id;
        n_cmd.hop_value = i_item.hop_value;
        n_cmd.link_hop  = (i_item.hop_value == 8'hFF) ? 8'hFF : i_item.hop_value + 8'd1;
        n_cmd.dec_hop   = (i_item.hop_value == 8'h00) ? 8'h00 : i_item.hop_value - 8'd1;

        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== rtl/mrte_queue.sv =====
// Two-entry command queue between front and back stages.
// Uses mrte_pkg for the command type and queue constants.
`timescale 1ns / 1ps

module mrte_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mrte_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output logic                 o_ready,
    output logic                 o_valid,
    output mrte_pkg::t_cmd       o_cmd
);

    mrte_pkg::t_cmd                r_slot [mrte_pkg::QUEUE_DEPTH];
    logic [mrte_pkg::QPTR_W-1:0]   r_wp, n_wp, r_rp, n_rp;
    logic [mrte_pkg::QCNT_W-1:0]   r_cnt, n_cnt;
    logic                          do_push, do_pop;

    assign o_ready = (r_cnt != mrte_pkg::QCNT_W'(mrte_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == mrte_pkg::QPTR_W'(mrte_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == mrte_pkg::QPTR_W'(mrte_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== rtl/mrte_back.sv =====
// Back stage: route table memory, scan sequencer and result register.
// Uses mrte_pkg; takes commands from mrte_queue and config from the top.
`timescale 1ns / 1ps

module mrte_back #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mrte_pkg::t_cfg       i_cfg,
    input  logic                 i_q_valid,
    input  mrte_pkg::t_cmd       i_q_cmd,
    output logic                 o_pop,
    output logic                 o_res_strobe,
    output mrte_pkg::t_result    o_result
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EXT_W = CNT_W + 5;

    // table memory: single write port, one registered read port
    mrte_pkg::t_entry    mem [TABLE_DEPTH];
    mrte_pkg::t_entry    r_rd_data;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    mrte_pkg::t_entry    mem_wdata;

    mrte_pkg::t_state    r_state, n_state;
    mrte_pkg::t_cmd      r_cmd, n_cmd;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [7:0]          r_best_hop, n_best_hop;
    logic [7:0]          r_best_dest, n_best_dest;
    logic                r_found, n_found;
    logic                r_fwd, n_fwd;
    logic                r_out_valid, n_out_valid;
    mrte_pkg::t_result   r_out, n_out;

    logic [CNT_W-1:0]    idx_inc;
    logic                scan_end, run_end, match, room;
    logic [EXT_W-1:0]    cur_ext, run_lim, inc_ext, new_ext;

    assign o_res_strobe = r_out_valid;
    assign o_result     = r_out;

    always_comb begin
        idx_inc  = r_idx + 1'b1;
        scan_end = (idx_inc == r_count);
        cur_ext  = EXT_W'(r_count);
        inc_ext  = EXT_W'(idx_inc);
        run_lim  = (cur_ext > EXT_W'(mrte_pkg::MAX_RUN)) ? EXT_W'(mrte_pkg::MAX_RUN) : cur_ext;
        run_end  = (inc_ext == run_lim);
        match    = (r_rd_data.dest == r_cmd.dest_id);
        room     = (r_count < CNT_W'(TABLE_DEPTH));

        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_count     = r_count;
        n_best_hop  = r_best_hop;
        n_best_dest = r_best_dest;
        n_found     = r_found;
        n_fwd       = r_fwd;
        n_out_valid = 1'b0;
        n_out       = '0;
        new_ext     = '0;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[IDX_W-1:0];
        mem_wdata   = '{dest: r_cmd.dest_id, hop: r_cmd.link_hop};

        unique case (r_state)
            mrte_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_fwd   = 1'b0;
                    if (i_q_cmd.op == mrte_pkg::OP_CLEAR || r_count == '0) begin
                        n_state = mrte_pkg::ST_FINISH;
                    end else begin
                        n_state = mrte_pkg::ST_READ;
                    end
                end
            end
            mrte_pkg::ST_READ: begin
                n_state = mrte_pkg::ST_CHECK;
            end
            mrte_pkg::ST_CHECK: begin
                unique case (r_cmd.op)
                    mrte_pkg::OP_UPDATE: begin
                        if (match) begin
                            // first hit ends the search; keep the shorter route
                            n_found = 1'b1;
                            n_state = mrte_pkg::ST_FINISH;
                            if (r_cmd.link_hop < r_rd_data.hop) begin
                                mem_we = 1'b1;
                            end
                        end else if (scan_end) begin
                            n_state = mrte_pkg::ST_FINISH;
                        end else begin
                            n_idx   = idx_inc;
                            n_state = mrte_pkg::ST_READ;
                        end
                    end
                    mrte_pkg::OP_CHECK: begin
                        if (match && r_cmd.hop_value <= r_rd_data.hop) begin
                            n_fwd = 1'b1;
                        end
                        if (scan_end) begin
                            n_state = mrte_pkg::ST_FINISH;
                        end else begin
                            n_idx   = idx_inc;
                            n_state = mrte_pkg::ST_READ;
                        end
                    end
                    mrte_pkg::OP_REQUEST: begin
                        new_ext           = EXT_W'(r_count);
                        n_out_valid       = 1'b1;
                        n_out.kind        = r_cmd.op;
                        n_out.entry_dest  = r_rd_data.dest;
                        n_out.entry_hop   = r_rd_data.hop;
                        n_out.entry_valid = 1'b1;
                        n_out.entry_count = new_ext[4:0];
                        n_out.best_dest   = r_best_dest;
                        n_out.best_hop    = r_best_hop;
                        n_out.last        = run_end;
                        if (run_end) begin
                            n_state = mrte_pkg::ST_IDLE;
                        end else begin
                            n_idx   = idx_inc;
                            n_state = mrte_pkg::ST_READ;
                        end
                    end
                    mrte_pkg::OP_CLEAR: begin
                        n_state = mrte_pkg::ST_FINISH;
                    end
                endcase
            end
            mrte_pkg::ST_FINISH: begin
                unique case (r_cmd.op)
                    mrte_pkg::OP_UPDATE: begin
                        if (!r_found) begin
                            if (room) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[IDX_W-1:0];
                                n_count   = r_count + 1'b1;
                            end else begin
                                n_out.dropped = 1'b1;
                            end
                        end
                        // best route follows dropped entries too
                        if (r_cmd.link_hop < r_best_hop) begin
                            n_best_hop  = r_cmd.link_hop;
                            n_best_dest = r_cmd.dest_id;
                        end
                    end
                    mrte_pkg::OP_CHECK: begin
                        n_out.forward     = r_fwd;
                        n_out.forward_hop = r_fwd ? r_cmd.dec_hop : 8'h00;
                    end
                    mrte_pkg::OP_REQUEST: begin
                        // empty table: a single result with no entry
                    end
                    mrte_pkg::OP_CLEAR: begin
                        if (i_cfg.is_gateway) begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = '{dest: i_cfg.gateway_id, hop: 8'h00};
                            n_count   = CNT_W'(1);
                        end else begin
                            n_count     = '0;
                            n_best_dest = 8'h00;
                            n_best_hop  = i_cfg.initial_hop_limit;
                        end
                    end
                endcase
                new_ext           = EXT_W'(n_count);
                n_out_valid       = 1'b1;
                n_out.kind        = r_cmd.op;
                n_out.entry_count = new_ext[4:0];
                n_out.best_dest   = n_best_dest;
                n_out.best_hop    = n_best_hop;
                n_out.last        = 1'b1;
                n_state           = mrte_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrte_pkg::ST_IDLE;
            r_idx       <= '0;
            r_count     <= '0;
            r_best_hop  <= 8'hFF;
            r_best_dest <= 8'h00;
            r_found     <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_best_hop  <= n_best_hop;
            r_best_dest <= n_best_dest;
            r_found     <= n_found;
            r_fwd       <= n_fwd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[r_idx[IDX_W-1:0]];
    end

endmodule

// ===== rtl/mesh_route_table_engine.sv =====
// Top level of the mesh route table engine: config registers, front stage,
// command queue and back stage. Uses mrte_pkg, mrte_front, mrte_queue, mrte_back.
//
//   channel   ports                               handshake
//   --------  ----------------------------------  ------------------------------
//   item in   start, busy, i_item                 taken when start && !busy
//   result    o_res_strobe, o_result              one-cycle strobe per result, no stall
//   config    i_cfg_we, i_cfg_idx, i_cfg_data     written when i_cfg_we is high
//
// Update and check ops pop the command, then scan the table one entry at a time
// (a read step, then a check step) and end with a finish step; an update stops
// at the first match. A route request emits one result per entry, up to MAX_RUN
// entries; a clear goes straight to finish. The table read is registered.
// Reset clears control state and the entry count; table contents need no clear.
// busy rises when the front register and the two-entry queue are both full.
`timescale 1ns / 1ps

module mesh_route_table_engine #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mrte_pkg::t_item      i_item,
    output logic                 o_res_strobe,
    output mrte_pkg::t_result    o_result,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [7:0]           i_cfg_data
);

    mrte_pkg::t_cfg  r_cfg, n_cfg;
    logic            push, q_ready, q_valid, pop;
    mrte_pkg::t_cmd  front_cmd, q_cmd;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (mrte_pkg::t_cfg_idx'(i_cfg_idx))
                mrte_pkg::CFG_IS_GATEWAY: n_cfg.is_gateway        = i_cfg_data[0];
                mrte_pkg::CFG_GATEWAY_ID: n_cfg.gateway_id        = i_cfg_data;
                mrte_pkg::CFG_HOP_LIMIT:  n_cfg.initial_hop_limit = i_cfg_data;
                mrte_pkg::CFG_UNUSED:     n_cfg                   = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.is_gateway        <= 1'b0;
            r_cfg.gateway_id        <= 8'd1;
            r_cfg.initial_hop_limit <= 8'hFF;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    mrte_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_item    (i_item),
        .i_q_ready (q_ready),
        .o_busy    (busy),
        .o_push    (push),
        .o_cmd     (front_cmd)
    );

    mrte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    mrte_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_pop        (pop),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result)
    );

endmodule

// ===== rtl/mrte_checker.sv =====
// Port-level checker for the mesh route table engine, bound to the top level.
// Uses mrte_pkg and mesh_route_table_engine_macros.svh.
`timescale 1ns / 1ps
`include "mesh_route_table_engine_macros.svh"

module mrte_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_res_strobe,
    input mrte_pkg::t_result  o_result
);

    logic [5:0] depth_cap;
    logic       not_request;
    logic       single_res;
    logic       entry_res;
    logic       idle_fwd;
    logic       count_ok;

    assign depth_cap   = (TABLE_DEPTH > 16) ? 6'd16 : 6'(TABLE_DEPTH);
    assign not_request = (o_result.kind != mrte_pkg::OP_REQUEST);
    assign single_res  = o_res_strobe && not_request;
    assign entry_res   = o_res_strobe && o_result.entry_valid;
    assign idle_fwd    = o_res_strobe && !o_result.forward;
    assign count_ok    = (TABLE_DEPTH > 16) || ({1'b0, o_result.entry_count} <= depth_cap);

    `MRTE_ASSERT_NEXT(a_reset_quiet, !i_rst_n, !o_res_strobe && !busy, "activity after reset")
    `MRTE_ASSERT_IMPL(a_single_last, single_res, o_result.last, "single result without last")
    `MRTE_ASSERT_IMPL(a_entry_kind, entry_res, !not_request, "entry on non-request result")
    `MRTE_ASSERT_IMPL(a_fwd_hop, idle_fwd, o_result.forward_hop == 8'h00, "hop without forward")
    `MRTE_ASSERT_IMPL(a_count_cap, o_res_strobe, count_ok, "count above depth")

endmodule

bind mesh_route_table_engine mrte_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_mrte_checker (.*);
